// ===== src/swsfd_pkg.sv =====
// swsfd_pkg: shared types and constants of the sliding window sync frame detector
// no dependencies; used by swsfd_front, swsfd_back and the top level

package swsfd_pkg;

    // byte, configuration index and frame index widths
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 1;
    localparam int INDEX_W   = 5;

    // register reset values
    localparam logic [BYTE_W-1:0] SYNC_FIRST_RESET  = 8'hAA;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RESET = 8'hBB;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SYNC_FIRST  = 1'b0,
        REG_SYNC_SECOND = 1'b1
    } cfg_reg_t;

    // sync marker pair as seen by the front
    typedef struct packed {
        logic [BYTE_W-1:0] first;
        logic [BYTE_W-1:0] second;
    } sync_pair_t;

endpackage

// ===== src/swsfd_front.sv =====
// swsfd_front: accepts bytes, keeps the sliding window and fill count, tests for a frame
// depends on swsfd_pkg; hands a matched window to swsfd_back

module swsfd_front #(
    parameter int HEAD_LEN = 13,
    parameter int TAIL_LEN = 19
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [swsfd_pkg::BYTE_W-1:0] rx_byte,
    input  swsfd_pkg::sync_pair_t       sync_pair,
    input  logic                        back_busy,
    output logic                        load,
    output logic [swsfd_pkg::BYTE_W-1:0] window [HEAD_LEN+TAIL_LEN]
);

    localparam int WIN_LEN = HEAD_LEN + TAIL_LEN;
    localparam int FILL_W  = $clog2(WIN_LEN + 2);
    localparam logic [FILL_W-1:0] FILL_SAT = FILL_W'(WIN_LEN + 1);

    logic [swsfd_pkg::BYTE_W-1:0] window_reg [WIN_LEN];
    logic [FILL_W-1:0]            fill_reg;
    logic [FILL_W-1:0]            fill_next;
    logic                         pend_reg;
    logic                         pend_next;
    logic                         accept;
    logic                         head_ok;
    logic                         tail_hit;

    assign accept   = in_valid && !pend_reg;
    assign in_stall = pend_reg;

    // window shift, oldest byte at position 0; payload needs no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int j = 0; j < WIN_LEN - 1; j++)
            begin
                window_reg[j] <= window_reg[j+1];
            end
            window_reg[WIN_LEN-1] <= rx_byte;
        end
    end

    assign window = window_reg;

    // sync pair at the end of the head
    assign head_ok = (window_reg[HEAD_LEN-2] == sync_pair.first) &&
                     (window_reg[HEAD_LEN-1] == sync_pair.second);

    // any sync pair wholly inside the tail
    always_comb
    begin
        tail_hit = 1'b0;
        for (int i = HEAD_LEN + 1; i < WIN_LEN; i++)
        begin
            if ((window_reg[i-1] == sync_pair.first) && (window_reg[i] == sync_pair.second))
            begin
                tail_hit = 1'b1;
            end
        end
    end

    // handoff of a matched window once the back is free
    assign load = pend_reg && head_ok && !tail_hit && !back_busy;

    // fill count and pending check
    always_comb
    begin
        fill_next = fill_reg;
        pend_next = pend_reg;
        if (accept)
        begin
            if (fill_reg != FILL_SAT)
            begin
                fill_next = fill_reg + 1'b1;
            end
            pend_next = (fill_next == FILL_SAT);
        end
        else if (pend_reg)
        begin
            if (!head_ok || tail_hit || !back_busy)
            begin
                pend_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            pend_reg <= pend_next;
        end
    end

endmodule

// ===== src/swsfd_back.sv =====
// swsfd_back: frame buffer that sends a matched window out oldest first
// depends on swsfd_pkg; loaded by swsfd_front

module swsfd_back #(
    parameter int WIN_LEN = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic [swsfd_pkg::BYTE_W-1:0]  window [WIN_LEN],
    output logic                          busy,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [swsfd_pkg::BYTE_W-1:0]  frame_byte,
    output logic [swsfd_pkg::INDEX_W-1:0] frame_index,
    output logic                          frame_last
);

    localparam int CNT_W = $clog2(WIN_LEN);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIN_LEN - 1);

    logic [swsfd_pkg::BYTE_W-1:0] frame_reg [WIN_LEN];
    logic [CNT_W-1:0]             cnt_reg;
    logic [CNT_W-1:0]             cnt_next;
    logic                         busy_reg;
    logic                         busy_next;
    logic                         send;
    logic [31:0]                  cnt_wide;

    assign send = busy_reg && !out_stall;

    // frame buffer: parallel load, shift out at position 0
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            frame_reg <= window;
        end
        else if (send)
        begin
            for (int j = 0; j < WIN_LEN - 1; j++)
            begin
                frame_reg[j] <= frame_reg[j+1];
            end
        end
    end

    // byte counter and busy flag
    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (load)
        begin
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (send)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    // outputs straight from registers; frame_last is decoded from the byte counter
    assign cnt_wide    = 32'(cnt_reg);
    assign busy        = busy_reg;
    assign out_valid   = busy_reg;
    assign frame_byte  = frame_reg[0];
    assign frame_index = cnt_wide[swsfd_pkg::INDEX_W-1:0];
    assign frame_last  = (cnt_reg == CNT_LAST);

endmodule

// ===== src/sliding_window_sync_frame_detector_unit.sv =====
// sliding_window_sync_frame_detector_unit: top level of the sync frame detector
// depends on swsfd_pkg, swsfd_front and swsfd_back
//
//  channel | signals                                    | direction
//  --------+--------------------------------------------+----------
//  in      | in_valid, in_stall, rx_byte                | request in
//  out     | out_valid, out_stall, frame_byte/index/last | request out
//  cfg     | cfg_we, cfg_index, cfg_data                | write only
//
// until the window is full and one byte beyond it, a byte is taken every cycle; after
// that each byte is registered into the window and in_stall is raised while the frame
// test runs on it, and longer while a matched window waits for the frame buffer
// a matched frame is sent as HEAD_LEN+TAIL_LEN bytes, one per cycle while out_stall is low
// the window keeps shifting while a frame drains; a match meanwhile waits, stalling input
// reset clears the fill count, handoff and buffer state, and loads the sync defaults

module sliding_window_sync_frame_detector_unit #(
    parameter int HEAD_LEN = 13,
    parameter int TAIL_LEN = 19
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [swsfd_pkg::BYTE_W-1:0]     rx_byte,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [swsfd_pkg::BYTE_W-1:0]     frame_byte,
    output logic [swsfd_pkg::INDEX_W-1:0]    frame_index,
    output logic                             frame_last,
    input  logic                             cfg_we,
    input  logic [swsfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [swsfd_pkg::BYTE_W-1:0]     cfg_data
);

    localparam int WIN_LEN = HEAD_LEN + TAIL_LEN;

    swsfd_pkg::sync_pair_t        sync_reg;
    logic                         back_load;
    logic                         back_busy;
    logic [swsfd_pkg::BYTE_W-1:0] window [WIN_LEN];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg.first  <= swsfd_pkg::SYNC_FIRST_RESET;
            sync_reg.second <= swsfd_pkg::SYNC_SECOND_RESET;
        end
        else if (cfg_we)
        begin
            unique case (swsfd_pkg::cfg_reg_t'(cfg_index))
                swsfd_pkg::REG_SYNC_FIRST:  sync_reg.first  <= cfg_data;
                swsfd_pkg::REG_SYNC_SECOND: sync_reg.second <= cfg_data;
                default: ;
            endcase
        end
    end

    // front: window and frame test
    swsfd_front #(
        .HEAD_LEN (HEAD_LEN),
        .TAIL_LEN (TAIL_LEN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .sync_pair (sync_reg),
        .back_busy (back_busy),
        .load      (back_load),
        .window    (window)
    );

    // back: frame buffer and output
    swsfd_back #(
        .WIN_LEN (WIN_LEN)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (back_load),
        .window      (window),
        .busy        (back_busy),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .frame_byte  (frame_byte),
        .frame_index (frame_index),
        .frame_last  (frame_last)
    );

    // a window is handed over only to an empty frame buffer
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        back_load |-> !back_busy)
        else $error("frame loaded while buffer busy");

    // a frame always starts at index zero
    a_first_index: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (frame_index == '0))
        else $error("frame did not start at index zero");

    // the marked byte ends the frame
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && frame_last) |=> !out_valid)
        else $error("output continued past the last byte");

    // a load starts a frame on the next cycle
    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        back_load |=> (out_valid && (frame_index == '0)))
        else $error("load did not start a frame");

endmodule

// ===== tb/sv/swsfd_frame_checker.sv =====
// swsfd_frame_checker: predicts the frames of the sync frame detector and checks every output byte
// watches the input, output and register ports of the block; depends on swsfd_pkg

module swsfd_frame_checker #(
    parameter int HEAD_LEN = 13,
    parameter int TAIL_LEN = 19
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic [swsfd_pkg::BYTE_W-1:0]     rx_byte,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [swsfd_pkg::BYTE_W-1:0]     frame_byte,
    input  logic [swsfd_pkg::INDEX_W-1:0]    frame_index,
    input  logic                             frame_last,
    input  logic                             cfg_we,
    input  logic [swsfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [swsfd_pkg::BYTE_W-1:0]     cfg_data,
    output int                               mismatch_count,
    output int                               bytes_due
);

    localparam int WIN_LEN = HEAD_LEN + TAIL_LEN;

    // one expected output byte
    typedef struct packed {
        logic [swsfd_pkg::BYTE_W-1:0]  data;
        logic [swsfd_pkg::INDEX_W-1:0] index;
        logic                          last;
    } frame_beat_t;

    frame_beat_t                   expected_beats[$];
    logic [swsfd_pkg::BYTE_W-1:0]  window [WIN_LEN];
    logic [swsfd_pkg::BYTE_W-1:0]  marker_first;
    logic [swsfd_pkg::BYTE_W-1:0]  marker_second;
    int                            fill;

    task automatic report(input string msg);
        $display("%0t: frame check: %s", $time, msg);
        mismatch_count++;
    endtask

    // marker pair at the end of the head, and no marker pair wholly inside the tail
    function automatic bit window_holds_frame();
        int i;
        if (window[HEAD_LEN-2] != marker_first || window[HEAD_LEN-1] != marker_second)
            return 1'b0;
        for (i = HEAD_LEN + 1; i < WIN_LEN; i++)
        begin
            if (window[i-1] == marker_first && window[i] == marker_second)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // shift a received byte in and, once the fill count has saturated, queue the whole window when it frames
    task automatic shift_in_byte(input logic [swsfd_pkg::BYTE_W-1:0] b);
        frame_beat_t beat;
        int k;
        for (k = 0; k < WIN_LEN - 1; k++)
            window[k] = window[k+1];
        window[WIN_LEN-1] = b;
        if (fill < WIN_LEN + 1)
            fill++;
        if (fill == WIN_LEN + 1 && window_holds_frame())
        begin
            for (k = 0; k < WIN_LEN; k++)
            begin
                beat.data  = window[k];
                beat.index = k[swsfd_pkg::INDEX_W-1:0];
                beat.last  = (k == WIN_LEN - 1);
                expected_beats = {expected_beats, beat};
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        frame_beat_t want;
        if (!rst_n)
        begin
            marker_first  = swsfd_pkg::SYNC_FIRST_RESET;
            marker_second = swsfd_pkg::SYNC_SECOND_RESET;
            fill          = 0;
            expected_beats.delete();
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                case (swsfd_pkg::cfg_reg_t'(cfg_index))
                    swsfd_pkg::REG_SYNC_FIRST:  marker_first  = cfg_data;
                    swsfd_pkg::REG_SYNC_SECOND: marker_second = cfg_data;
                    default: ;
                endcase
            end
            // output request against the oldest expected byte
            if (out_valid && !out_stall)
            begin
                if (expected_beats.size() == 0)
                    report($sformatf("unexpected frame byte %02h index %0d last %0b",
                                     frame_byte, frame_index, frame_last));
                else
                begin
                    want = expected_beats.pop_front();
                    if (frame_byte !== want.data)
                        report($sformatf("frame_byte %02h, expected %02h at index %0d",
                                         frame_byte, want.data, want.index));
                    if (frame_index !== want.index)
                        report($sformatf("frame_index %0d, expected %0d",
                                         frame_index, want.index));
                    if (frame_last !== want.last)
                        report($sformatf("frame_last %0b, expected %0b at index %0d",
                                         frame_last, want.last, want.index));
                end
            end
            // input request
            if (in_valid && !in_stall)
                shift_in_byte(rx_byte);
        end
        bytes_due = expected_beats.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
// testbench: stimulus and verdict for sliding_window_sync_frame_detector_unit
// depends on swsfd_pkg, the block itself and swsfd_frame_checker

module testbench;

    localparam int HEAD_LEN      = 13;
    localparam int TAIL_LEN      = 19;
    localparam int WIN_LEN       = HEAD_LEN + TAIL_LEN;
    localparam int CLOCK_LIMIT   = 600000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 40;
    localparam int PHASE_BYTES   = 32;
    localparam int LAST_PHASE    = 5;

    logic                             clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_stall;
    logic [swsfd_pkg::BYTE_W-1:0]     rx_byte;
    logic                             out_valid;
    logic                             out_stall;
    logic [swsfd_pkg::BYTE_W-1:0]     frame_byte;
    logic [swsfd_pkg::INDEX_W-1:0]    frame_index;
    logic                             frame_last;
    logic                             cfg_we;
    logic [swsfd_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [swsfd_pkg::BYTE_W-1:0]     cfg_data;

    int                               mismatch_count;
    int                               bytes_due;
    int                               cycle_count;
    int                               bytes_in_phase;
    int                               sender_quiet;
    logic                             calm;
    logic                             hold_req;
    logic [swsfd_pkg::BYTE_W-1:0]     marker_first;
    logic [swsfd_pkg::BYTE_W-1:0]     marker_second;

    sliding_window_sync_frame_detector_unit #(
        .HEAD_LEN(HEAD_LEN),
        .TAIL_LEN(TAIL_LEN)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .frame_byte(frame_byte),
        .frame_index(frame_index),
        .frame_last(frame_last),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    swsfd_frame_checker #(
        .HEAD_LEN(HEAD_LEN),
        .TAIL_LEN(TAIL_LEN)
    ) frame_check (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .frame_byte(frame_byte),
        .frame_index(frame_index),
        .frame_last(frame_last),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .mismatch_count(mismatch_count),
        .bytes_due(bytes_due)
    );

    // clock
    initial
        clk = 1'b0;
    always #5 clk = ~clk;

    // run limit
    initial
        cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CLOCK_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold-off on request, none at the end
    initial
    begin : receiver
        int n;
        bit hold_done;
        hold_done = 1'b0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 6) == 0)
            begin
                n = $urandom_range(1, 13);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if ($urandom_range(0, 19) == 0)
            begin
                n = $urandom_range(20, 60);
                out_stall <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else
                out_stall <= 1'b0;
        end
    end

    // random byte leaning toward the marker bytes and the extremes
    function automatic logic [swsfd_pkg::BYTE_W-1:0] pick_byte();
        logic [swsfd_pkg::BYTE_W-1:0] r;
        r = swsfd_pkg::BYTE_W'($urandom_range(0, 255));
        case ($urandom_range(0, 7))
            0: r = marker_first;
            1: r = marker_second;
            2: r = 8'h00;
            3: r = 8'hFF;
            default: ;
        endcase
        return r;
    endfunction

    // one input request, with an occasional gap before it
    task automatic send_byte(input logic [swsfd_pkg::BYTE_W-1:0] b);
        int gap;
        if (sender_quiet > 0)
            sender_quiet--;
        else if (!calm && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 13);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        else if ($urandom_range(0, 24) == 0)
            sender_quiet = $urandom_range(10, 40);
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_in_phase++;
    endtask

    task automatic send_noise(input int n);
        int k;
        for (k = 0; k < n; k++)
            send_byte(pick_byte());
    endtask

    // a full window that frames on its last byte, unless a marker pair is planted in the tail
    task automatic send_frame(input bit plant_pair, input bit lead_second);
        logic [swsfd_pkg::BYTE_W-1:0] frame [WIN_LEN];
        int pair_at;
        int k;
        pair_at = $urandom_range(HEAD_LEN + 1, WIN_LEN - 1);
        for (k = 0; k < HEAD_LEN - 2; k++)
            frame[k] = pick_byte();
        frame[HEAD_LEN-2] = marker_first;
        frame[HEAD_LEN-1] = marker_second;
        for (k = HEAD_LEN; k < WIN_LEN; k++)
        begin
            if (plant_pair && k == pair_at - 1)
                frame[k] = marker_first;
            else if (plant_pair && k == pair_at)
                frame[k] = marker_second;
            else if (lead_second && k == HEAD_LEN)
                frame[k] = marker_second;
            else
            begin
                frame[k] = pick_byte();
                // the first tail byte is left free: it never pairs with the head
                if (k > HEAD_LEN && frame[k-1] == marker_first && frame[k] == marker_second)
                    frame[k] = marker_second + 8'd1;
            end
        end
        for (k = 0; k < WIN_LEN; k++)
            send_byte(frame[k]);
    endtask

    // drop valid, wait until every frame byte is out, then let the block settle
    task automatic wait_idle(input int settle);
        in_valid <= 1'b0;
        @(posedge clk);
        while (bytes_due != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_markers(input logic [swsfd_pkg::BYTE_W-1:0] first_val,
                                 input logic [swsfd_pkg::BYTE_W-1:0] second_val);
        cfg_we    <= 1'b1;
        cfg_index <= swsfd_pkg::REG_SYNC_FIRST;
        cfg_data  <= first_val;
        @(posedge clk);
        cfg_index <= swsfd_pkg::REG_SYNC_SECOND;
        cfg_data  <= second_val;
        @(posedge clk);
        cfg_we <= 1'b0;
        marker_first  = first_val;
        marker_second = second_val;
    endtask

    // stimulus and verdict
    initial
    begin : stimulus
        int phase;
        logic [swsfd_pkg::BYTE_W-1:0] next_first;
        logic [swsfd_pkg::BYTE_W-1:0] next_second;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        rx_byte        = '0;
        cfg_we         = 1'b0;
        cfg_index      = swsfd_pkg::REG_SYNC_FIRST;
        cfg_data       = '0;
        calm           = 1'b0;
        hold_req       = 1'b0;
        sender_quiet   = 0;
        bytes_in_phase = 0;
        marker_first   = swsfd_pkg::SYNC_FIRST_RESET;
        marker_second  = swsfd_pkg::SYNC_SECOND_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill count not yet saturated: a framing pattern as the very first bytes gives nothing
        send_frame(1'b0, 1'b0);

        for (phase = 0; phase <= LAST_PHASE; phase++)
        begin
            // marker settings: reset values, both extremes, an equal pair, random
            if (phase > 0)
            begin
                case (phase)
                    1:
                    begin
                        next_first  = 8'h00;
                        next_second = 8'hFF;
                    end
                    2:
                    begin
                        next_first  = 8'h55;
                        next_second = 8'h55;
                    end
                    3:
                    begin
                        next_first  = 8'hFF;
                        next_second = 8'h00;
                    end
                    default:
                    begin
                        next_first  = swsfd_pkg::BYTE_W'($urandom_range(0, 255));
                        next_second = swsfd_pkg::BYTE_W'($urandom_range(0, 255));
                    end
                endcase
                wait_idle(SETTLE_CYCLES);
                write_markers(next_first, next_second);
            end
            if (phase == LAST_PHASE)
                calm <= 1'b1;
            bytes_in_phase = 0;

            // back-to-back frames while the receiver holds off
            if (phase == 0)
            begin
                hold_req <= 1'b1;
                send_frame(1'b0, 1'b0);
                send_frame(1'b0, 1'b0);
            end
            // equal markers: a marker byte opening the tail must not break the frame
            if (phase == 2)
                send_frame(1'b0, 1'b1);

            while (bytes_in_phase < PHASE_BYTES)
            begin
                if ($urandom_range(0, 9) < 7)
                    send_frame($urandom_range(0, 4) == 0, $urandom_range(0, 3) == 0);
                else
                    send_noise($urandom_range(1, 20));
            end
        end

        wait_idle(DRAIN_CYCLES);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
